/* src/ssrch_pkg.sv */
// ---------------------------------------------------------------------------
// ssrch_pkg
// Shared types and constants for the streaming substring search block.
// ---------------------------------------------------------------------------
package ssrch_pkg;

   localparam int BYTE_W      = 8;
   localparam int POS_W       = 32;
   localparam int REQ_W       = 2;
   localparam int QUEUE_DEPTH = 2;

   // request codes as they arrive on the request channel
   typedef enum logic [REQ_W-1:0] {
      REQ_CLEAR  = 2'd0,
      REQ_APPEND = 2'd1,
      REQ_HAY    = 2'd2
   } req_code_type;

   // classified request passed from front to back
   typedef struct packed {
      req_code_type      code;
      logic [BYTE_W-1:0] data;
   } item_type;

endpackage

/* src/ssrch_if.sv */
// ---------------------------------------------------------------------------
// ssrch request / response channels
// Valid-ready channels carrying the request and response payloads.
// ---------------------------------------------------------------------------
interface ssrch_req_if
   import ssrch_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output req_type, output data_byte, input ready);
   modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

interface ssrch_rsp_if
   import ssrch_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic             found;
   logic [POS_W-1:0] match_position;
   logic             needle_truncated;

   modport source (output valid, output found, output match_position,
                   output needle_truncated, input ready);
   modport sink   (input valid, input found, input match_position,
                   input needle_truncated, output ready);
endinterface

/* src/ssrch_front.sv */
// ---------------------------------------------------------------------------
// ssrch_front
// Request intake: decodes the request code, drops no-op requests and holds
// one classified item for the queue.
// ---------------------------------------------------------------------------
module ssrch_front
   import ssrch_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [REQ_W-1:0]  in_code,
   input  logic [BYTE_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output item_type          out_item
);

   logic     valid_ff, valid_in;
   item_type item_ff;
   logic     accept;
   logic     keep;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   // append of a zero byte and the unused code do nothing
   always_comb begin
      case (req_code_type'(in_code))
         REQ_CLEAR:  keep = 1'b1;
         REQ_APPEND: keep = (in_data != '0);
         REQ_HAY:    keep = 1'b1;
         default:    keep = 1'b0;
      endcase
   end

   assign valid_in = accept ? keep : (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         item_ff.code <= req_code_type'(in_code);
         item_ff.data <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

/* src/ssrch_queue.sv */
// ---------------------------------------------------------------------------
// ssrch_queue
// Small FIFO decoupling the front from the back.
// ---------------------------------------------------------------------------
module ssrch_queue
   import ssrch_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* src/ssrch_back.sv */
// ---------------------------------------------------------------------------
// ssrch_back
// Needle store, shift-and matcher, position counter and response register.
// ---------------------------------------------------------------------------
module ssrch_back
   import ssrch_pkg::*;
#(
   parameter int MAX_NEEDLE = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  item_type         in_item,
   output logic             out_valid,
   input  logic             out_ready,
   output logic             out_found,
   output logic [POS_W-1:0] out_position,
   output logic             out_truncated
);

   localparam int N     = MAX_NEEDLE;
   localparam int LEN_W = $clog2(N + 1);

   // needle bytes; entries at or above the length are stale and masked off
   logic [BYTE_W-1:0] store_ff [N];
   logic [N-1:0]      len_mask_ff, len_mask_in;   // thermometer of needle length
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [N-1:0]      pm_ff, pm_in;
   logic [POS_W-1:0]  count_ff, count_in;
   logic              finished_ff, finished_in;
   logic              overflow_ff, overflow_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff;
   logic [POS_W-1:0]  rsp_pos_ff;
   logic              rsp_trunc_ff;

   logic [N-1:0]      eq_vec;
   logic [N-1:0]      last_oh;
   logic [N-1:0]      wr_oh;
   logic [N-1:0]      pm_step;
   logic              pop;
   logic              store_wr;
   logic              emit;
   logic              emit_found;
   logic [POS_W-1:0]  emit_pos;
   logic              empty, full, term;

   assign in_ready = !rsp_valid_ff || out_ready;
   assign pop      = in_valid && in_ready;

   assign empty   = !len_mask_ff[0];
   assign full    = len_mask_ff[N-1];
   assign term    = (in_item.data == '0);
   assign last_oh = len_mask_ff & ~(len_mask_ff >> 1);
   assign wr_oh   = ~len_mask_ff & ((len_mask_ff << 1) | N'(1));

   for (genvar i = 0; i < N; i++) begin : g_cmp
      assign eq_vec[i] = (store_ff[i] == in_item.data);
   end

   assign pm_step = ((pm_ff << 1) | N'(1)) & eq_vec & len_mask_ff;

   always_comb begin
      len_mask_in = len_mask_ff;
      len_in      = len_ff;
      pm_in       = pm_ff;
      count_in    = count_ff;
      finished_in = finished_ff;
      overflow_in = overflow_ff;
      store_wr    = 1'b0;
      emit        = 1'b0;
      emit_found  = 1'b0;
      emit_pos    = '0;
      if (pop) begin
         case (in_item.code)
            REQ_CLEAR: begin
               len_mask_in = '0;
               len_in      = '0;
               overflow_in = 1'b0;
               pm_in       = '0;
               count_in    = '0;
               finished_in = 1'b0;
            end
            REQ_APPEND: begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  store_wr    = 1'b1;
                  len_mask_in = (len_mask_ff << 1) | N'(1);
                  len_in      = len_ff + 1'b1;
               end
               pm_in       = '0;
               count_in    = '0;
               finished_in = 1'b0;
            end
            REQ_HAY: begin
               if (finished_ff) begin
                  if (term) begin
                     pm_in       = '0;
                     count_in    = '0;
                     finished_in = 1'b0;
                  end
               end else if (empty) begin
                  emit       = 1'b1;
                  emit_found = 1'b1;
                  if (term) begin
                     pm_in       = '0;
                     count_in    = '0;
                     finished_in = 1'b0;
                  end else begin
                     finished_in = 1'b1;
                  end
               end else if (term) begin
                  emit        = 1'b1;
                  pm_in       = '0;
                  count_in    = '0;
                  finished_in = 1'b0;
               end else begin
                  if (count_ff != '1) begin
                     count_in = count_ff + 1'b1;
                  end
                  if ((pm_step & last_oh) != '0) begin
                     emit        = 1'b1;
                     emit_found  = 1'b1;
                     emit_pos    = count_ff + POS_W'(1) - POS_W'(len_ff);
                     finished_in = 1'b1;
                     pm_in       = '0;
                  end else begin
                     pm_in = pm_step;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = (pop && emit) ? 1'b1 : (rsp_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_mask_ff  <= '0;
         len_ff       <= '0;
         pm_ff        <= '0;
         count_ff     <= '0;
         finished_ff  <= 1'b0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_mask_ff  <= len_mask_in;
         len_ff       <= len_in;
         pm_ff        <= pm_in;
         count_ff     <= count_in;
         finished_ff  <= finished_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_store
      always_ff @(posedge clock) begin
         if (store_wr && wr_oh[i]) begin
            store_ff[i] <= in_item.data;
         end
      end
   end

   // overflow only changes on needle requests, so the current flag is exact
   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_found_ff <= emit_found;
         rsp_pos_ff   <= emit_pos;
         rsp_trunc_ff <= overflow_ff;
      end
   end

   assign out_valid     = rsp_valid_ff;
   assign out_found     = rsp_found_ff;
   assign out_position  = rsp_pos_ff;
   assign out_truncated = rsp_trunc_ff;

endmodule

/* src/streaming_substring_search.sv */
// ---------------------------------------------------------------------------
// streaming_substring_search
// First-occurrence search of a stored needle in a zero-terminated haystack.
// ---------------------------------------------------------------------------
//  channel  | dir | payload                                       | handshake
//  ---------+-----+-----------------------------------------------+----------
//  req_bus  | in  | req_type[1:0], data_byte[7:0]                 | valid/ready
//  rsp_bus  | out | found, match_position[31:0], needle_truncated | valid/ready
//
//  One request per cycle sustained while responses are taken; a request
//  passes through the front register, the queue and the response register.
//  The per-entry needle compare plus shift-and vector handle one byte a cycle.
//  reset is synchronous, active high; no clearing pass, ready right after it.
//  A stalled response holds the back; the two-entry queue and the front
//  register keep taking requests until they fill.
// ---------------------------------------------------------------------------
module streaming_substring_search
   import ssrch_pkg::*;
#(
   parameter int MAX_NEEDLE = 64
) (
   input logic       clock,
   input logic       reset,
   ssrch_req_if.sink   req_bus,
   ssrch_rsp_if.source rsp_bus
);

   // front -> queue
   logic     fq_valid, fq_ready;
   item_type fq_item;
   // queue -> back
   logic     qb_valid, qb_ready;
   item_type qb_item;

   // decode and drop no-op requests
   ssrch_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_code   (req_bus.req_type),
      .in_data   (req_bus.data_byte),
      .out_valid (fq_valid),
      .out_ready (fq_ready),
      .out_item  (fq_item)
   );

   // lets the front keep accepting while the response side stalls
   ssrch_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_item  (fq_item),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_item   (qb_item)
   );

   // needle store, matcher and response register
   ssrch_back #(
      .MAX_NEEDLE (MAX_NEEDLE)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (qb_valid),
      .in_ready      (qb_ready),
      .in_item       (qb_item),
      .out_valid     (rsp_bus.valid),
      .out_ready     (rsp_bus.ready),
      .out_found     (rsp_bus.found),
      .out_position  (rsp_bus.match_position),
      .out_truncated (rsp_bus.needle_truncated)
   );

endmodule

/* src/ssrch_checker.sv */
// ---------------------------------------------------------------------------
// ssrch_checker
// Port-level assertions for the streaming substring search block.
// ---------------------------------------------------------------------------
module ssrch_checker
   import ssrch_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_found,
   input logic [POS_W-1:0] rsp_position,
   input logic             rsp_truncated
);

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_found) && $stable(rsp_position) && $stable(rsp_truncated))
      else $error("response payload changed while stalled");

   // not-found responses carry position zero
   a_miss_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("not-found response with nonzero position");

   // nothing pending right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind streaming_substring_search ssrch_checker u_ssrch_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_found     (rsp_bus.found),
   .rsp_position  (rsp_bus.match_position),
   .rsp_truncated (rsp_bus.needle_truncated)
);
